// ===== hw/rtl/rlp_pkg.sv =====
`timescale 1ns / 1ps
package rlp_pkg;

  localparam int LENGTH_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int MAX_BYTES        = 9;

  localparam logic [7:0] STR_SHORT_BASE  = 8'h80;
  localparam logic [7:0] STR_LONG_BASE   = 8'hB7;
  localparam logic [7:0] LIST_SHORT_BASE = 8'hC0;
  localparam logic [7:0] LIST_LONG_BASE  = 8'hF7;
  localparam logic [7:0] SINGLE_MAX      = 8'h7F;
  localparam logic [7:0] SHORT_LEN_MAX   = 8'd55;
  localparam logic [63:0] SAT_LEN        = '1;

  typedef enum logic [1:0] {
    REQ_INT      = 2'd0,
    REQ_STR_HDR  = 2'd1,
    REQ_STR_DATA = 2'd2,
    REQ_LIST     = 2'd3
  } rlp_req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ROOM = 2'd1,
    ST_SEQ  = 2'd2
  } rlp_status_t;

  // One queued job: either up to nine bytes to stream, or one status-only result.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [3:0]                cnt;
    logic                      has_data;
    logic [63:0]               enc_len;
    rlp_status_t               status;
  } rlp_job_t;

endpackage

// ===== hw/rtl/rlp_in_if.sv =====
`timescale 1ns / 1ps
interface rlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] value;
  logic [7:0]  data_byte;
  logic [63:0] out_room;

  modport source (output valid, req_type, value, data_byte, out_room, input ready);
  modport sink   (input valid, req_type, value, data_byte, out_room, output ready);
endinterface

// ===== hw/rtl/rlp_out_if.sv =====
`timescale 1ns / 1ps
interface rlp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [63:0] encoded_length;
  logic [1:0]  status;

  modport source (output valid, out_byte, byte_valid, last, encoded_length, status,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, encoded_length, status,
                  output ready);
endinterface

// ===== hw/rtl/rlp_item_encoder.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Contents
// in_ch   | sink      | req_type, value, data_byte, out_room
// out_ch  | source    | out_byte, byte_valid, last, encoded_length, status
//
// A request is classified and encoded in the cycle it is accepted and its bytes are
// queued; its first result passes through the queue into the registered output.
// String payload bytes pass at one per cycle while out_ch.ready is high; a header or
// integer holds the output until all of its bytes (up to nine) are emitted, while the
// job queue takes up to QUEUE_DEPTH-1 further jobs, after which in_ch.ready drops.
// Reset (rst_n low, synchronous) clears the open-string state, queue and output.
// A stalled output fills the queue in the same way.
module rlp_item_encoder
  import rlp_pkg::*;
#(
  parameter int LENGTH_BYTES = LENGTH_BYTES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rlp_in_if.sink     in_ch,
  rlp_out_if.source  out_ch
);

  logic     fire;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  rlp_job_t job;
  rlp_job_t head;

  assign in_ch.ready = !full;
  assign fire        = in_ch.valid && !full;

  rlp_front #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req_type (in_ch.req_type),
    .value    (in_ch.value),
    .data_byte(in_ch.data_byte),
    .out_room (in_ch.out_room),
    .push     (push),
    .job      (job)
  );

  rlp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(job),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  rlp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

// ===== hw/rtl/rlp_front.sv =====
`timescale 1ns / 1ps
module rlp_front
  import rlp_pkg::*;
#(
  parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [1:0]  req_type,
  input  logic [63:0] value,
  input  logic [7:0]  data_byte,
  input  logic [63:0] out_room,
  output logic        push,
  output rlp_job_t    job
);

  localparam int LEN_W = 8 * LENGTH_BYTES;

  logic [LEN_W-1:0] br_r, br_nxt;
  logic             single_r, single_nxt;
  logic             room2_r, room2_nxt;
  logic             drop_r, drop_nxt;

  logic [63:0]                len64;
  logic [3:0]                 int_nb, hdr_nb;
  logic [MAX_BYTES-1:0][7:0]  int_buf, hdr_buf;
  logic [3:0]                 int_n, hdr_n;
  logic [64:0]                sum;
  logic [63:0]                total;
  logic [LEN_W-1:0]           br_dec;
  logic                       int_small;
  logic                       is_list;

  function automatic logic [3:0] byte_count(input logic [63:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[8*i +: 8] != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Big-endian bytes of v, nb of them, placed from position one onward.
  function automatic logic [MAX_BYTES-1:0][7:0] be_tail(input logic [63:0] v,
                                                        input logic [3:0] nb);
    logic [MAX_BYTES-1:0][7:0] b;
    logic [63:0]               sh;
    logic [6:0]                amt;
    b   = '0;
    amt = 7'({3'd0, 4'd8 - nb} << 3);
    sh  = v << amt;
    for (int k = 0; k < 8; k++) begin
      b[k+1] = sh[63-8*k -: 8];
    end
    return b;
  endfunction

  always_comb begin
    len64     = 64'(value[LEN_W-1:0]);
    is_list   = (rlp_req_t'(req_type) == REQ_LIST);

    int_nb    = byte_count(value);
    int_small = (value <= 64'(SINGLE_MAX));
    int_buf   = be_tail(value, int_nb);
    if (value == 64'd0) begin
      int_buf[0] = STR_SHORT_BASE;
    end else if (int_small) begin
      int_buf[0] = value[7:0];
    end else begin
      int_buf[0] = STR_SHORT_BASE + {4'd0, int_nb};
    end
    int_n = int_small ? 4'd1 : 4'd1 + int_nb;

    hdr_nb  = byte_count(len64);
    hdr_buf = be_tail(len64, hdr_nb);
    if (len64 <= 64'(SHORT_LEN_MAX)) begin
      hdr_buf[0] = (is_list ? LIST_SHORT_BASE : STR_SHORT_BASE) + len64[7:0];
      hdr_n      = 4'd1;
    end else begin
      hdr_buf[0] = (is_list ? LIST_LONG_BASE : STR_LONG_BASE) + {4'd0, hdr_nb};
      hdr_n      = 4'd1 + hdr_nb;
    end

    sum   = {1'b0, len64} + 65'(hdr_n);
    total = sum[64] ? SAT_LEN : sum[63:0];
    br_dec = br_r - LEN_W'(1);
  end

  always_comb begin
    push       = 1'b0;
    job        = '0;
    job.cnt    = 4'd1;
    job.status = ST_OK;
    br_nxt     = br_r;
    single_nxt = single_r;
    room2_nxt  = room2_r;
    drop_nxt   = drop_r;

    if (fire) begin
      if (rlp_req_t'(req_type) == REQ_STR_DATA) begin
        if (single_r) begin
          single_nxt = 1'b0;
          room2_nxt  = 1'b0;
          drop_nxt   = 1'b0;
          push       = 1'b1;
          if (data_byte <= SINGLE_MAX) begin
            job.enc_len = 64'd1;
            if (drop_r) begin
              job.status = ST_ROOM;
            end else begin
              job.has_data = 1'b1;
              job.bytes[0] = data_byte;
            end
          end else begin
            job.enc_len = 64'd2;
            if (!room2_r) begin
              job.status = ST_ROOM;
            end else begin
              job.has_data = 1'b1;
              job.cnt      = 4'd2;
              job.bytes[0] = STR_SHORT_BASE + 8'd1;
              job.bytes[1] = data_byte;
            end
          end
        end else if (br_r != '0) begin
          br_nxt = br_dec;
          if (drop_r) begin
            if (br_dec == '0) drop_nxt = 1'b0;
          end else begin
            push         = 1'b1;
            job.has_data = 1'b1;
            job.bytes[0] = data_byte;
          end
        end else begin
          push       = 1'b1;
          job.status = ST_SEQ;
        end
      end else if (br_r != '0 || single_r) begin
        push       = 1'b1;
        job.status = ST_SEQ;
      end else begin
        case (rlp_req_t'(req_type))
          REQ_INT: begin
            push        = 1'b1;
            job.enc_len = 64'(int_n);
            if (out_room < 64'(int_n)) begin
              job.status = ST_ROOM;
            end else begin
              job.has_data = 1'b1;
              job.cnt      = int_n;
              job.bytes    = int_buf;
            end
          end
          REQ_LIST: begin
            push        = 1'b1;
            job.enc_len = 64'(hdr_n);
            if (out_room < 64'(hdr_n)) begin
              job.status = ST_ROOM;
            end else begin
              job.has_data = 1'b1;
              job.cnt      = hdr_n;
              job.bytes    = hdr_buf;
            end
          end
          REQ_STR_HDR: begin
            if (len64 == 64'd0) begin
              push        = 1'b1;
              job.enc_len = 64'd1;
              if (out_room == 64'd0) begin
                job.status = ST_ROOM;
              end else begin
                job.has_data = 1'b1;
                job.bytes[0] = STR_SHORT_BASE;
              end
            end else if (len64 == 64'd1) begin
              // A one-byte string: the encoding depends on the byte still to come.
              single_nxt = 1'b1;
              room2_nxt  = (out_room >= 64'd2);
              drop_nxt   = (out_room == 64'd0);
            end else begin
              push        = 1'b1;
              job.enc_len = total;
              br_nxt      = value[LEN_W-1:0];
              if (out_room < total) begin
                drop_nxt   = 1'b1;
                job.status = ST_ROOM;
              end else begin
                drop_nxt     = 1'b0;
                job.has_data = 1'b1;
                job.cnt      = hdr_n;
                job.bytes    = hdr_buf;
              end
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r     <= '0;
      single_r <= 1'b0;
      room2_r  <= 1'b0;
      drop_r   <= 1'b0;
    end else begin
      br_r     <= br_nxt;
      single_r <= single_nxt;
      room2_r  <= room2_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule

// ===== hw/rtl/rlp_queue.sv =====
`timescale 1ns / 1ps
module rlp_queue
  import rlp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rlp_job_t push_job,
  output logic     full,
  input  logic     pop,
  output rlp_job_t head,
  output logic     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rlp_job_t       mem_r [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    if (do_pop)  rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + (AW+1)'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/rlp_back.sv =====
`timescale 1ns / 1ps
module rlp_back
  import rlp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  rlp_job_t      head,
  input  logic          empty,
  output logic          pop,
  rlp_out_if.source     out_ch
);

  logic [3:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        bval_r;
  logic        last_r;
  logic [63:0] enc_r;
  logic [1:0]  st_r;
  logic        load;
  logic        is_last;

  // The output register takes a new byte when it is empty or being drained.
  assign load    = !empty && (!vld_r || out_ch.ready);
  assign is_last = (idx_r == head.cnt - 4'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.has_data ? head.bytes[idx_r] : 8'd0;
      bval_r <= head.has_data;
      last_r <= is_last;
      enc_r  <= head.enc_len;
      st_r   <= head.status;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.out_byte       = byte_r;
  assign out_ch.byte_valid     = bval_r;
  assign out_ch.last           = last_r;
  assign out_ch.encoded_length = enc_r;
  assign out_ch.status         = st_r;

endmodule

// ===== verif/rlp_item_encoder_test.sv =====
`timescale 1ns / 1ps
module rlp_item_encoder_test
  import rlp_pkg::*;
();

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_TAIL   = 40;
  localparam logic [63:0] LEN_MASK = (LENGTH_BYTES_DEF >= 8) ? '1 :
                                     ((64'd1 << (8 * LENGTH_BYTES_DEF)) - 64'd1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [63:0] enc_len;
    rlp_status_t status;
  } rlp_result_t;

  logic clk;
  logic rst_n;

  rlp_in_if  in_ch ();
  rlp_out_if out_ch ();

  rlp_item_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rlp_result_t expected_q[$];

  // Encoder state as the block should hold it.
  logic [63:0] pay_left;
  bit          one_byte_wait;
  bit          one_byte_room2;
  bit          drop_payload;

  int fail_count     = 0;
  int cycle_count    = 0;
  int items_sent     = 0;
  bit idling         = 1'b1;
  bit hold_out       = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int count_bytes(logic [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 8;
    end
    return n;
  endfunction

  // Bytes needed for the whole encoding of a request; for a one-byte string,
  // the worst case of two.
  function automatic logic [63:0] needed_room(rlp_req_t rt, logic [63:0] value);
    logic [63:0] len;
    int hdr;
    len = value & LEN_MASK;
    case (rt)
      REQ_INT: return (value <= 64'h7f) ? 64'd1 : 64'(1 + count_bytes(value));
      REQ_LIST: return (len <= SHORT_LEN_MAX) ? 64'd1 : 64'(1 + count_bytes(len));
      REQ_STR_HDR: begin
        if (len <= 64'd1) return len + 64'd1;
        hdr = (len <= SHORT_LEN_MAX) ? 1 : 1 + count_bytes(len);
        return (len > SAT_LEN - 64'(hdr)) ? SAT_LEN : len + 64'(hdr);
      end
      default: return 64'd0;
    endcase
  endfunction

  // Prefix byte base + byte count, then the big-endian bytes without leading zeros.
  function automatic int be_field(logic [63:0] v, logic [7:0] base,
                                  output logic [8:0][7:0] hb);
    int nb;
    hb = '0;
    nb = count_bytes(v);
    hb[0] = base + 8'(nb);
    for (int i = 0; i < nb; i++) hb[1 + i] = 8'(v >> (8 * (nb - 1 - i)));
    return 1 + nb;
  endfunction

  function automatic int push_status(logic [63:0] enc, rlp_status_t st);
    expected_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                           enc_len: enc, status: st});
    return 1;
  endfunction

  function automatic int push_bytes(logic [8:0][7:0] hb, int n, logic [63:0] enc);
    for (int i = 0; i < n; i++) begin
      expected_q.push_back('{out_byte: hb[i], byte_valid: 1'b1, last: (i == n - 1),
                             enc_len: enc, status: ST_OK});
    end
    return n;
  endfunction

  // Updates the encoder state for one accepted transaction and queues its results.
  function automatic int predict_encoding(rlp_req_t rt, logic [63:0] value,
                                          logic [7:0] db, logic [63:0] room);
    logic [63:0] len;
    logic [63:0] need;
    logic [8:0][7:0] hb;
    int n;
    bit ok;
    len = value & LEN_MASK;
    need = needed_room(rt, value);
    hb = '0;
    if (rt == REQ_STR_DATA) begin
      if (one_byte_wait) begin
        one_byte_wait = 1'b0;
        if (db <= SINGLE_MAX) begin
          hb[0] = db;
          n = 1;
          ok = !drop_payload;
        end else begin
          hb[0] = STR_SHORT_BASE + 8'd1;
          hb[1] = db;
          n = 2;
          ok = one_byte_room2;
        end
        drop_payload = 1'b0;
        one_byte_room2 = 1'b0;
        if (!ok) return push_status(64'(n), ST_ROOM);
        return push_bytes(hb, n, 64'(n));
      end
      if (pay_left != 0) begin
        pay_left--;
        if (drop_payload) begin
          if (pay_left == 0) drop_payload = 1'b0;
          return 0;
        end
        hb[0] = db;
        return push_bytes(hb, 1, 64'd0);
      end
      return push_status(64'd0, ST_SEQ);
    end

    if (pay_left != 0 || one_byte_wait) return push_status(64'd0, ST_SEQ);

    case (rt)
      REQ_INT: begin
        if (value == 0) begin
          hb[0] = STR_SHORT_BASE;
          n = 1;
        end else if (value <= 64'h7f) begin
          hb[0] = value[7:0];
          n = 1;
        end else begin
          n = be_field(value, STR_SHORT_BASE, hb);
        end
      end
      REQ_LIST: begin
        if (len <= SHORT_LEN_MAX) begin
          hb[0] = LIST_SHORT_BASE + len[7:0];
          n = 1;
        end else begin
          n = be_field(len, LIST_LONG_BASE, hb);
        end
      end
      default: begin
        if (len == 0) begin
          hb[0] = STR_SHORT_BASE;
          n = 1;
        end else if (len == 1) begin
          one_byte_wait = 1'b1;
          one_byte_room2 = (room >= 64'd2);
          drop_payload = (room == 0);
          return 0;
        end else begin
          if (len <= SHORT_LEN_MAX) begin
            hb[0] = STR_SHORT_BASE + len[7:0];
            n = 1;
          end else begin
            n = be_field(len, STR_LONG_BASE, hb);
          end
          pay_left = len;
          drop_payload = (room < need);
        end
      end
    endcase
    if (room < need) return push_status(need, ST_ROOM);
    return push_bytes(hb, n, need);
  endfunction

  function automatic logic [63:0] rand_value();
    int nb;
    logic [63:0] v;
    nb = $urandom_range(0, 8);
    v = {$urandom, $urandom};
    if (nb < 8) v &= (64'd1 << (8 * nb)) - 64'd1;
    return v;
  endfunction

  function automatic logic [63:0] pick_room(logic [63:0] need);
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return need - 64'd1;
      2: return need;
      3: return {$urandom, $urandom};
      default: return need + 64'($urandom_range(0, 40));
    endcase
  endfunction

  // Offers one request and returns once the transaction has completed.
  task automatic send_item(rlp_req_t rt, logic [63:0] value, logic [7:0] db,
                           logic [63:0] room);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rt;
    in_ch.value     <= value;
    in_ch.data_byte <= db;
    in_ch.out_room  <= room;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(predict_encoding(rt, value, db, room));
    items_sent++;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_integers();
    idling = 1'b1;
    send_item(REQ_INT, 64'd0, 8'h00, 64'd1);
    send_item(REQ_INT, 64'h7f, 8'hff, 64'd1);
    send_item(REQ_INT, 64'h80, 8'h00, 64'd2);
    send_item(REQ_INT, SAT_LEN, 8'h5a, SAT_LEN);
    send_item(REQ_INT, 64'h100, 8'ha5, 64'd2);
    wait_results();
  endtask

  task automatic test_strings();
    idling = 1'b1;
    send_item(REQ_STR_HDR, 64'd0, 8'h00, 64'd0);
    // One-byte strings: room decides between the byte, 0x81 and the byte, or a room error.
    send_item(REQ_STR_HDR, 64'd1, 8'h00, 64'd2);
    send_item(REQ_STR_DATA, 64'd0, 8'h85, 64'd0);
    send_item(REQ_STR_HDR, 64'd1, 8'h00, 64'd1);
    send_item(REQ_STR_DATA, 64'd0, 8'h90, 64'd0);
    send_item(REQ_STR_HDR, 64'd1, 8'h00, 64'd0);
    send_item(REQ_STR_DATA, 64'd0, 8'h10, 64'd0);
    send_item(REQ_STR_DATA, 64'd0, 8'haa, 64'd0);
    // A request in the middle of a payload is out of sequence.
    send_item(REQ_STR_HDR, 64'd2, 8'h00, 64'd4);
    send_item(REQ_INT, 64'd7, 8'h00, 64'd9);
    send_item(REQ_STR_DATA, 64'd0, 8'h01, 64'd0);
    send_item(REQ_STR_DATA, 64'd0, 8'hfe, 64'd0);
    // Room too small: the payload that follows is dropped silently.
    send_item(REQ_STR_HDR, 64'd2, 8'h00, 64'd2);
    send_item(REQ_STR_DATA, 64'd0, 8'h33, 64'd0);
    send_item(REQ_STR_DATA, 64'd0, 8'h44, 64'd0);
    wait_results();
  endtask

  task automatic test_lists();
    idling = 1'b1;
    send_item(REQ_LIST, 64'd55, 8'h00, 64'd1);
    send_item(REQ_LIST, 64'd56, 8'h00, 64'd1);
    send_item(REQ_LIST, SAT_LEN, 8'h00, 64'd9);
    wait_results();
  endtask

  task automatic test_pressure();
    idling = 1'b0;
    hold_out = 1'b1;
    for (int i = 0; i < 12; i++) send_item(REQ_INT, SAT_LEN - 64'(i), 8'h00, SAT_LEN);
    wait_results();
  endtask

  task automatic run_sequences(int target, bit allow_idle);
    int start_count;
    int kind;
    int len;
    int inject_at;
    rlp_req_t inj_req;
    logic [63:0] v;
    start_count = items_sent;
    idling = allow_idle;
    while (items_sent - start_count < target) begin
      if (allow_idle && $urandom_range(0, 11) == 0) idling = !idling;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        v = ($urandom_range(0, 5) == 0) ? 64'h7f + 64'($urandom_range(0, 1)) : rand_value();
        send_item(REQ_INT, v, 8'($urandom), pick_room(needed_room(REQ_INT, v)));
      end else if (kind < 40) begin
        v = ($urandom_range(0, 2) == 0) ? rand_value() : 64'($urandom_range(0, 70));
        send_item(REQ_LIST, v, 8'($urandom), pick_room(needed_room(REQ_LIST, v)));
      end else if (kind < 90) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 5);
          7, 8: len = $urandom_range(6, 60);
          default: len = $urandom_range(56, 120);
        endcase
        v = 64'(len);
        send_item(REQ_STR_HDR, v, 8'($urandom), pick_room(needed_room(REQ_STR_HDR, v)));
        inject_at = (len > 0 && $urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == inject_at) begin
            case ($urandom_range(0, 2))
              0: inj_req = REQ_INT;
              1: inj_req = REQ_STR_HDR;
              default: inj_req = REQ_LIST;
            endcase
            send_item(inj_req, rand_value(), 8'($urandom), {$urandom, $urandom});
          end
          send_item(REQ_STR_DATA, rand_value(), 8'($urandom), {$urandom, $urandom});
        end
      end else begin
        send_item(REQ_STR_DATA, rand_value(), 8'($urandom), {$urandom, $urandom});
      end
    end
    wait_results();
  endtask

  // Runs with no idling; the saturating string stays open, so it comes last.
  task automatic test_saturated_length();
    run_sequences(40, 1'b0);
    send_item(REQ_STR_HDR, SAT_LEN, 8'h00, SAT_LEN);
    for (int i = 0; i < 3; i++) send_item(REQ_STR_DATA, 64'd0, 8'($urandom), 64'd0);
    wait_results();
  endtask

  initial begin : sink_driver
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    rlp_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_valid %0b status %0d",
               out_ch.out_byte, out_ch.byte_valid, out_ch.status);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.out_byte !== exp_r.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", exp_r.out_byte, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.byte_valid !== exp_r.byte_valid) begin
          $error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, out_ch.byte_valid);
          fail_count++;
        end
        if (out_ch.last !== exp_r.last) begin
          $error("last: expected %0b, actual %0b", exp_r.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.encoded_length !== exp_r.enc_len) begin
          $error("encoded_length: expected %0h, actual %0h", exp_r.enc_len,
                 out_ch.encoded_length);
          fail_count++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    pay_left       = '0;
    one_byte_wait  = 1'b0;
    one_byte_room2 = 1'b0;
    drop_payload   = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_INT;
    in_ch.value     <= '0;
    in_ch.data_byte <= '0;
    in_ch.out_room  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_integers();
    test_strings();
    test_lists();
    test_pressure();
    run_sequences(380, 1'b1);
    test_saturated_length();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
